// ===== rtl/coordinate_deque_with_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Coordinate deque assertion macros
// Shared concurrent assertion forms for the coordinate deque RTL.
// ----------------------------------------------------------------------------
`ifndef COORDINATE_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define COORDINATE_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Coordinate deque package
// Default sizes, request codes and the engine result bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int COORD_BITS_DEFAULT = 8;
  localparam int COUNT_OUT_BITS     = 7;

  typedef enum logic [1:0] {
    REQ_ADD_LAST    = 2'd0,
    REQ_ADD_FIRST   = 2'd1,
    REQ_REMOVE_LAST = 2'd2,
    REQ_SEARCH      = 2'd3
  } req_type_t;

  // Finished request as handed from the engine to the output stage.
  typedef struct packed {
    logic                      done;
    logic                      ok;
    logic                      empty;
    logic [COUNT_OUT_BITS-1:0] entry_count;
  } cdq_result_t;

endpackage

// ===== rtl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// Coordinate deque ring store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module cdq_ram import cdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int WIDTH = 2 * COORD_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/cdq_engine.sv =====
// ----------------------------------------------------------------------------
// Coordinate deque engine
// Pointer and count keeping, ring slot adder and the shared scan comparator.
// ----------------------------------------------------------------------------
`include "coordinate_deque_with_search_core_defines.svh"

module cdq_engine import cdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [COORD_BITS-1:0]     coord_x,
  input  logic [COORD_BITS-1:0]     coord_y,
  input  logic                      take,
  output cdq_result_t               res,
  output logic                      wr_en,
  output logic [$clog2(DEPTH)-1:0]  wr_addr,
  output logic [2*COORD_BITS-1:0]   wr_data,
  output logic                      rd_en,
  output logic [$clog2(DEPTH)-1:0]  rd_addr,
  input  logic [2*COORD_BITS-1:0]   rd_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   first, first_next;
  logic [CW-1:0]   scan_off, scan_off_next;
  logic [PW-1:0]   pair, pair_next;
  logic            ok_r, ok_next;
  logic            rd_pend, rd_pend_next;

  logic            fire, full, empty, issue, match, is_add;
  logic [CW-1:0]   off_sel;
  logic [SW-1:0]   sum, slot;
  logic [IW-1:0]   slot_idx, first_dec;
  logic [31:0]     cnt_wide;
  req_type_t       req;

  assign req      = req_type_t'(req_type);
  assign in_ready = (state == ST_IDLE);
  assign fire     = in_valid && in_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign is_add   = (req == REQ_ADD_LAST) || (req == REQ_ADD_FIRST);

  // Shared ring slot adder: last end on an add, scan offset during a search.
  assign off_sel  = (state == ST_SCAN) ? scan_off : count;
  assign sum      = SW'(first) + SW'(off_sel);
  assign slot     = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign slot_idx = slot[IW-1:0];
  assign first_dec = (first == '0) ? IW'(DEPTH - 1) : (first - 1'b1);

  assign wr_en   = fire && !full && is_add;
  assign wr_addr = (req == REQ_ADD_FIRST) ? first_dec : slot_idx;
  assign wr_data = {coord_x, coord_y};

  // Shared comparator sees the entry read in the previous cycle.
  assign issue   = (state == ST_SCAN) && (scan_off < count);
  assign rd_en   = issue;
  assign rd_addr = slot_idx;
  assign match   = rd_pend && (rd_data == pair);

  always_comb begin
    state_next    = state;
    count_next    = count;
    first_next    = first;
    scan_off_next = scan_off;
    pair_next     = pair;
    ok_next       = ok_r;
    rd_pend_next  = issue && !match;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          pair_next  = {coord_x, coord_y};
          ok_next    = 1'b0;
          state_next = ST_DONE;
          case (req)
            REQ_ADD_LAST: begin
              if (!full) begin
                count_next = count + 1'b1;
                ok_next    = 1'b1;
              end
            end
            REQ_ADD_FIRST: begin
              if (!full) begin
                first_next = first_dec;
                count_next = count + 1'b1;
                ok_next    = 1'b1;
              end
            end
            REQ_REMOVE_LAST: begin
              if (!empty) begin
                count_next = count - 1'b1;
                ok_next    = 1'b1;
              end
            end
            REQ_SEARCH: begin
              scan_off_next = '0;
              state_next    = ST_SCAN;
            end
            default: begin
              ok_next = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_off_next = scan_off + 1'b1;
        end
        if (match) begin
          ok_next    = 1'b1;
          state_next = ST_DONE;
        end else if (!issue && !rd_pend) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      first   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      first   <= first_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_off <= scan_off_next;
    pair     <= pair_next;
    ok_r     <= ok_next;
  end

  assign cnt_wide        = 32'(count);
  assign res.done        = (state == ST_DONE);
  assign res.ok          = ok_r;
  assign res.empty       = empty;
  assign res.entry_count = cnt_wide[COUNT_OUT_BITS-1:0];

  `CDQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")
  `CDQ_ASSERT_NEXT(a_scan_holds_ptrs, clk, rst, state == ST_SCAN, $stable(count) && $stable(first), "pointers moved during search")
  `CDQ_ASSERT_NEXT(a_done_holds, clk, rst, (state == ST_DONE) && !take, (state == ST_DONE) && $stable(ok_r), "result dropped before handoff")
  `CDQ_ASSERT_NEXT(a_add_counts, clk, rst, fire && is_add && !full, count == $past(count) + CW'(1), "add did not grow count")

endmodule

// ===== rtl/coordinate_deque_with_search_core.sv =====
// ----------------------------------------------------------------------------
// Coordinate deque with search
// Bounded double-ended queue of (x, y) pairs with a membership search.
// ----------------------------------------------------------------------------
// Each request adds a pair at the last end, adds a pair at the first end,
// removes the pair at the last end, or searches for a pair, and returns one
// result (ok, entry_count, is_empty) through a one-deep output register, so a
// new request is taken while the previous result still waits. Requests are
// handled one at a time: an add or remove is accepted, then hands its result
// to the output register; a search walks the stored entries in turn and ends
// early on a hit, because the ring store has a single registered read port
// and the shared comparator checks one stored entry per cycle. A full store
// rejects adds with ok low, an empty store rejects removes with ok low, and a
// search of an empty store gives ok low. Only the low COORD_BITS bits of each
// coordinate are held. The store is not cleared at reset; only the pointer
// and count are.
// ----------------------------------------------------------------------------
module coordinate_deque_with_search_core import cdq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [COORD_BITS-1:0]     coord_x,
  input  logic [COORD_BITS-1:0]     coord_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [COUNT_OUT_BITS-1:0] entry_count,
  output logic                      is_empty
);

  localparam int IW = $clog2(DEPTH);
  localparam int PW = 2 * COORD_BITS;

  cdq_result_t   res;
  logic          take;
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] wr_data, rd_data;

  // Sequencer, pointers and the shared slot adder and comparator.
  cdq_engine #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .take     (take),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Ring store of packed pairs, x in the high half.
  cdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Move a finished result into the output register whenever it is empty or
  // being drained in this cycle; otherwise hold the engine in its done state.
  assign take = res.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the payload with the request's result; hold it while stalled.
  always_ff @(posedge clk) begin
    if (take) begin
      ok          <= res.ok;
      entry_count <= res.entry_count;
      is_empty    <= res.empty;
    end
  end

endmodule
